/* src/alfs_pkg.sv */
// Package for the addressable LED frame serializer.
// Holds sizes, command and op codes, and the structs shared by all modules.
// No dependencies.
package alfs_pkg;

    localparam int PIXEL_COUNT = 64;
    localparam int RESET_SLOTS = 48;
    localparam int Q_DEPTH     = 4;

    localparam int IDX_W = $clog2(PIXEL_COUNT);
    localparam int PTR_W = $clog2(PIXEL_COUNT + 1);
    localparam int RS_W  = $clog2(RESET_SLOTS + 1);
    localparam int Q_AW  = $clog2(Q_DEPTH);
    localparam int Q_CW  = $clog2(Q_DEPTH + 1);

    localparam int PIX_W  = 24;
    localparam int DUTY_W = 8;
    localparam int ZBD_W  = 7;

    localparam logic [7:0] GREEN_SCALE = 8'hB0;
    localparam logic [7:0] BLUE_SCALE  = 8'hF0;

    localparam logic [PTR_W-1:0] PIXEL_END = PTR_W'(PIXEL_COUNT);
    localparam logic [RS_W-1:0]  RS_LAST   = RS_W'(RESET_SLOTS);
    localparam logic [4:0]       BIT_LAST  = 5'd23;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } t_op_kind;

    typedef enum logic {
        BS_FETCH = 1'b0,
        BS_EMIT  = 1'b1
    } t_bstate;

    typedef struct packed {
        t_op_kind         kind;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] grb;
    } t_op;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              frame_active;
        logic              frame_end;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* src/addressable_led_frame_serializer.sv */
// Result path: a slot tick's result passes through the op queue, the pixel store read and the
// output register; writes and starts give no result.
// Throughput: writes and starts retire one per cycle while the sequencer is not held in its
// emit state; a slot tick takes a store read, then an emit that waits on the output register.
// Reset: synchronous, active low; clears store valid bits, counters, op queue, output valid at once.
// Top level; depends on alfs_pkg, alfs_front, alfs_queue, alfs_back, alfs_ram.
module addressable_led_frame_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: zero-bit compare value
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    // input transactions
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_pixel_index,
    input  logic [23:0] i_color,
    // result transactions
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_duty,
    output logic        o_frame_active,
    output logic        o_frame_end
);
    import alfs_pkg::*;

    t_op       w_front_op;
    t_op       w_head_op;
    t_q_status w_q_status;
    t_result   w_result;
    logic      w_q_push;
    logic      w_q_pop;
    logic      w_out_valid;

    // Front end: decode and color scaling. Out-of-range writes and
    // unknown commands are dropped here, so the sequencer never sees them.
    alfs_front u_front (
        .i_push        (push),
        .i_command     (i_command),
        .i_pixel_index (i_pixel_index),
        .i_color       (i_color),
        .i_q_status    (w_q_status),
        .o_q_push      (w_q_push),
        .o_op          (w_front_op)
    );

    // Op queue keeps input acceptance going while the sequencer waits
    // on a full output register.
    alfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_op     (w_front_op),
        .i_pop    (w_q_pop),
        .o_op     (w_head_op),
        .o_status (w_q_status)
    );

    // Sequencer: applies ops in order, so a write during a frame reaches
    // every pixel not yet sent.
    alfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (w_head_op),
        .i_q_status  (w_q_status),
        .o_q_pop     (w_q_pop),
        .i_pop       (pop),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign full           = w_q_status.full;
    assign empty          = !w_out_valid;
    assign o_duty         = w_result.duty;
    assign o_frame_active = w_result.frame_active;
    assign o_frame_end    = w_result.frame_end;

endmodule

/* src/alfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/alfs_front.sv */
// Front end: decodes accepted transactions into ops and scales colors.
// Depends on alfs_pkg.
module alfs_front (
    input  logic                      i_push,
    input  logic [1:0]                i_command,
    input  logic [7:0]                i_pixel_index,
    input  logic [23:0]               i_color,
    input  alfs_pkg::t_q_status       i_q_status,
    output logic                      o_q_push,
    output alfs_pkg::t_op             o_op
);
    import alfs_pkg::*;

    logic        w_accept;
    logic        w_in_range;
    logic        w_keep;
    logic [15:0] w_g_prod;
    logic [15:0] w_b_prod;

    assign w_accept   = i_push && !i_q_status.full;
    assign w_in_range = {1'b0, i_pixel_index} < 9'(PIXEL_COUNT);

    // green * 176 / 256 and blue * 240 / 256, floor
    assign w_g_prod = 16'(i_color[15:8]) * 16'(GREEN_SCALE);
    assign w_b_prod = 16'(i_color[7:0]) * 16'(BLUE_SCALE);

    always_comb begin
        w_keep       = 1'b0;
        o_op.kind    = OP_TICK;
        o_op.idx     = i_pixel_index[IDX_W-1:0];
        o_op.grb     = {w_g_prod[15:8], i_color[23:16], w_b_prod[15:8]};
        unique case (i_command)
            CMD_WRITE: begin
                o_op.kind = OP_WRITE;
                w_keep    = w_in_range;
            end
            CMD_START: begin
                o_op.kind = OP_START;
                w_keep    = 1'b1;
            end
            CMD_TICK: begin
                o_op.kind = OP_TICK;
                w_keep    = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    // dropped writes and unknown commands never reach the queue
    assign o_q_push = w_accept && w_keep;

endmodule

/* src/alfs_queue.sv */
// Small op queue between the front end and the frame sequencer.
// Depends on alfs_pkg.
module alfs_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  alfs_pkg::t_op        i_op,
    input  logic                 i_pop,
    output alfs_pkg::t_op        o_op,
    output alfs_pkg::t_q_status  o_status
);
    import alfs_pkg::*;

    t_op             r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_status.full  = r_count == Q_CW'(Q_DEPTH);
    assign o_status.empty = r_count == '0;
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_op   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/alfs_back.sv */
// Frame sequencer: owns the pixel store, runs frames and emits slot results.
// Depends on alfs_pkg and alfs_ram.
module alfs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [6:0]           i_cfg_wdata,
    input  alfs_pkg::t_op        i_op,
    input  alfs_pkg::t_q_status  i_q_status,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_out_valid,
    output alfs_pkg::t_result    o_result
);
    import alfs_pkg::*;

    t_bstate           r_state;
    t_bstate           n_state;
    logic              r_busy;
    logic              n_busy;
    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W-1:0]  n_ptr;
    logic [4:0]        r_bit_pos;
    logic [4:0]        n_bit_pos;
    logic [RS_W-1:0]   r_rs_cnt;
    logic [RS_W-1:0]   n_rs_cnt;
    logic [PIXEL_COUNT-1:0] r_valid;
    logic              r_rd_valid;
    logic [ZBD_W-1:0]  r_zbd;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_result;

    logic              w_ram_we;
    logic              w_ram_re;
    logic              w_out_free;
    logic              w_emit;
    logic              w_in_data;
    logic [PIX_W-1:0]  w_rdata;
    logic [PIX_W-1:0]  w_word;
    logic              w_bit;
    logic [RS_W-1:0]   w_rs_next;

    alfs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIXEL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_op.idx),
        .i_wdata (i_op.grb),
        .i_re    (w_ram_re),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || i_pop;
    assign w_in_data  = r_ptr < PIXEL_END;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_FETCH: begin
                if (!i_q_status.empty && i_op.kind == OP_TICK) begin
                    n_state = BS_EMIT;
                end
            end
            BS_EMIT: begin
                if (w_out_free) begin
                    n_state = BS_FETCH;
                end
            end
            default: n_state = BS_FETCH;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop  = 1'b0;
        w_ram_we = 1'b0;
        w_ram_re = 1'b0;
        w_emit   = 1'b0;
        unique case (r_state)
            BS_FETCH: begin
                o_q_pop  = !i_q_status.empty;
                w_ram_we = !i_q_status.empty && i_op.kind == OP_WRITE;
                w_ram_re = !i_q_status.empty && i_op.kind == OP_TICK;
            end
            BS_EMIT: begin
                w_emit = w_out_free;
            end
            default: ;
        endcase
    end

    // frame counters and slot result
    assign w_word    = r_rd_valid ? w_rdata : '0;
    assign w_bit     = w_word[BIT_LAST - r_bit_pos];
    assign w_rs_next = r_rs_cnt + 1'b1;

    always_comb begin
        n_busy    = r_busy;
        n_ptr     = r_ptr;
        n_bit_pos = r_bit_pos;
        n_rs_cnt  = r_rs_cnt;
        n_result  = '0;
        if (o_q_pop && i_op.kind == OP_START && !r_busy) begin
            n_busy    = 1'b1;
            n_ptr     = '0;
            n_bit_pos = '0;
            n_rs_cnt  = '0;
        end
        if (w_emit && r_busy) begin
            n_result.frame_active = 1'b1;
            if (w_in_data) begin
                n_result.duty = w_bit ? {r_zbd, 1'b0} : {1'b0, r_zbd};
                if (r_bit_pos == BIT_LAST) begin
                    n_bit_pos = '0;
                    n_ptr     = r_ptr + 1'b1;
                end else begin
                    n_bit_pos = r_bit_pos + 1'b1;
                end
            end else begin
                n_rs_cnt = w_rs_next;
                if (w_rs_next >= RS_LAST) begin
                    n_result.frame_end = 1'b1;
                    n_busy    = 1'b0;
                    n_ptr     = '0;
                    n_bit_pos = '0;
                    n_rs_cnt  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_FETCH;
            r_busy      <= 1'b0;
            r_ptr       <= '0;
            r_bit_pos   <= '0;
            r_rs_cnt    <= '0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_zbd       <= ZBD_W'(19);
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_busy    <= n_busy;
            r_ptr     <= n_ptr;
            r_bit_pos <= n_bit_pos;
            r_rs_cnt  <= n_rs_cnt;
            if (i_cfg_we) begin
                r_zbd <= i_cfg_wdata;
            end
            if (w_ram_we) begin
                r_valid[i_op.idx] <= 1'b1;
            end
            if (w_ram_re) begin
                r_rd_valid <= w_in_data && r_valid[r_ptr[IDX_W-1:0]];
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

/* src/alfs_checker.sv */
// Port-level checks for the addressable LED frame serializer, bound to the top.
// Depends on addressable_led_frame_serializer.
module alfs_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] o_duty,
    input  logic       o_frame_active,
    input  logic       o_frame_end
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

    a_end_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> o_frame_active)
        else $error("frame end outside a frame");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_frame_active) |-> (o_duty == 8'd0))
        else $error("nonzero duty while idle");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> (o_duty == 8'd0))
        else $error("nonzero duty on last reset slot");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_duty) && $stable(o_frame_end)))
        else $error("waiting result changed");

endmodule

bind addressable_led_frame_serializer alfs_checker u_alfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_duty         (o_duty),
    .o_frame_active (o_frame_active),
    .o_frame_end    (o_frame_end)
);

/* bench/led_slot_checker.sv */
// Result checker for the addressable LED frame serializer bench.
// Watches the config, input and result channels, predicts each slot and compares.
// Depends on alfs_pkg.
`timescale 1ns / 1ps

module led_slot_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [alfs_pkg::ZBD_W-1:0] i_cfg_wdata,
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic [1:0]                 i_command,
    input  logic [7:0]                 i_pixel_index,
    input  logic [23:0]                i_color,
    input  logic                       i_empty,
    input  logic                       i_pop,
    input  logic [alfs_pkg::DUTY_W-1:0] i_duty,
    input  logic                       i_frame_active,
    input  logic                       i_frame_end,
    output int                         o_mismatches,
    output int                         o_slots_owed
);
    import alfs_pkg::*;

    localparam logic [7:0] GREEN_MUL = 8'hB0;
    localparam logic [7:0] BLUE_MUL  = 8'hF0;

    // predicted strip state
    logic [PIX_W-1:0] grb_store [PIXEL_COUNT];
    logic             sending;
    logic [PTR_W-1:0] pix_ptr;
    logic [4:0]       bit_pos;
    logic [RS_W-1:0]  rs_cnt;
    logic [ZBD_W-1:0] zero_duty;

    t_result slots_owed [$];
    int      errs;

    function automatic logic [7:0] scale8(input logic [7:0] x, input logic [7:0] f);
        logic [15:0] prod;
        prod = x * f;
        return prod[15:8];
    endfunction

    task automatic clear_strip();
        for (int i = 0; i < PIXEL_COUNT; i++) grb_store[i] = '0;
        sending   = 1'b0;
        pix_ptr   = '0;
        bit_pos   = '0;
        rs_cnt    = '0;
        zero_duty = ZBD_W'(19);
        slots_owed.delete();
    endtask

    // One accepted transaction: update the strip state, queue the slot for a tick.
    task automatic advance_strip(input logic [1:0] cmd, input logic [7:0] idx,
                                 input logic [23:0] rgb);
        t_result slot;
        logic    bit_val;
        case (cmd)
            CMD_WRITE: begin
                if (idx < PIXEL_COUNT)
                    grb_store[idx[IDX_W-1:0]] = {scale8(rgb[15:8], GREEN_MUL), rgb[23:16],
                                                 scale8(rgb[7:0], BLUE_MUL)};
            end
            CMD_START: begin
                if (!sending) begin
                    sending = 1'b1;
                    pix_ptr = '0;
                    bit_pos = '0;
                    rs_cnt  = '0;
                end
            end
            CMD_TICK: begin
                slot = '0;
                if (sending) begin
                    slot.frame_active = 1'b1;
                    if (pix_ptr < PIXEL_COUNT) begin
                        // MSB first, green byte first
                        bit_val = grb_store[pix_ptr[IDX_W-1:0]][5'd23 - bit_pos];
                        slot.duty = bit_val ? {zero_duty, 1'b0} : {1'b0, zero_duty};
                        if (bit_pos == 5'd23) begin
                            bit_pos = '0;
                            pix_ptr = pix_ptr + 1'b1;
                        end else begin
                            bit_pos = bit_pos + 1'b1;
                        end
                    end else begin
                        rs_cnt = rs_cnt + 1'b1;
                        if (rs_cnt == RESET_SLOTS) begin
                            slot.frame_end = 1'b1;
                            sending = 1'b0;
                            pix_ptr = '0;
                            bit_pos = '0;
                            rs_cnt  = '0;
                        end
                    end
                end
                slots_owed.push_back(slot);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_strip();
        end else begin
            if (i_cfg_we) zero_duty = i_cfg_wdata;
            if (i_pop && !i_empty) begin
                if (slots_owed.size() == 0) begin
                    $error("unexpected result: duty %0d, frame_active %0b, frame_end %0b",
                           i_duty, i_frame_active, i_frame_end);
                    errs++;
                end else begin
                    want = slots_owed.pop_front();
                    if (i_duty !== want.duty) begin
                        $error("duty: expected %0d, actual %0d", want.duty, i_duty);
                        errs++;
                    end
                    if (i_frame_active !== want.frame_active) begin
                        $error("frame_active: expected %0b, actual %0b",
                               want.frame_active, i_frame_active);
                        errs++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, actual %0b",
                               want.frame_end, i_frame_end);
                        errs++;
                    end
                end
            end
            if (i_push && !i_full) advance_strip(i_command, i_pixel_index, i_color);
        end
        // registered so the stimulus side samples them without a race
        o_slots_owed  <= slots_owed.size();
        o_mismatches  <= errs;
    end

endmodule

/* bench/tb_addressable_led_frame_serializer.sv */
// Top of the addressable LED frame serializer bench: clock, reset, stimulus, verdict.
// Depends on alfs_pkg, led_slot_checker and the serializer RTL.
`timescale 1ns / 1ps

module tb_addressable_led_frame_serializer;
    import alfs_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;   // not decoded, must be ignored
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 10;    // well above the result latency
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int PHASE_MIN    = 150;   // random transactions per config phase
    localparam int PHASES       = 5;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ZBD_W-1:0]  i_cfg_wdata;
    logic              push;
    logic              full;
    logic [1:0]        i_command;
    logic [7:0]        i_pixel_index;
    logic [23:0]       i_color;
    logic              empty;
    logic              pop;
    logic [DUTY_W-1:0] o_duty;
    logic              o_frame_active;
    logic              o_frame_end;

    int mismatches;
    int slots_owed;
    int cycles;

    // shared between stimulus and the pop process
    bit calm;       // no idling on either side while set
    int hold_req;   // bumped to ask the receiver for a long hold-off

    addressable_led_frame_serializer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_pixel_index  (i_pixel_index),
        .i_color        (i_color),
        .empty          (empty),
        .pop            (pop),
        .o_duty         (o_duty),
        .o_frame_active (o_frame_active),
        .o_frame_end    (o_frame_end)
    );

    led_slot_checker slot_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .i_full         (full),
        .i_command      (i_command),
        .i_pixel_index  (i_pixel_index),
        .i_color        (i_color),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_duty         (o_duty),
        .i_frame_active (o_frame_active),
        .i_frame_end    (o_frame_end),
        .o_mismatches   (mismatches),
        .o_slots_owed   (slots_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run guard: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: pops at random (about 15% idle), never idles while calm is set,
    // and holds off for HOLD_CYCLES whenever the stimulus bumps hold_req.
    // The hold is counted here so the sender keeps offering meanwhile.
    always @(posedge i_clk) begin
        static int hold_seen = 0;
        static int hold_left = 0;
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    // Offer one transaction; returns at the edge where it was taken.
    // A random gap before it (unless calm) puts idle cycles on every phase of the work.
    task automatic offer(input logic [1:0] cmd, input logic [7:0] idx, input logic [23:0] rgb);
        int gap;
        if (!calm && $urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, 4);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_command     <= cmd;
        i_pixel_index <= idx;
        i_color       <= rgb;
        do @(posedge i_clk); while (full !== 1'b0);
    endtask

    // Stop offering and wait until every owed slot came out. Writes and starts
    // leave nothing owed but may still be in flight, hence the extra cycles.
    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (slots_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly slot ticks so frames run deep; some writes (mostly in range,
    // landing mid-frame too), a few starts, and the odd reserved command.
    task automatic random_item();
        int         pick;
        logic [1:0] cmd;
        logic [7:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 88)      cmd = CMD_TICK;
        else if (pick < 96) cmd = CMD_WRITE;
        else if (pick < 99) cmd = CMD_START;
        else                cmd = CMD_RESERVED;
        if ($urandom_range(0, 99) < 80) idx = 8'($urandom_range(0, PIXEL_COUNT - 1));
        else                            idx = 8'($urandom_range(PIXEL_COUNT, 255));
        offer(cmd, idx, 24'($urandom()));
    endtask

    initial begin
        int               n;
        logic [ZBD_W-1:0] phase_duty [PHASES];

        // zero-bit duty per phase; phase 0 runs on the reset value
        phase_duty[0] = ZBD_W'(19);
        phase_duty[1] = ZBD_W'(127);
        phase_duty[2] = ZBD_W'(0);
        phase_duty[3] = ZBD_W'(64);
        phase_duty[4] = ZBD_W'($urandom_range(1, 126));

        calm          = 1'b0;
        hold_req      = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        push          <= 1'b0;
        i_command     <= CMD_WRITE;
        i_pixel_index <= '0;
        i_color       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every command, the special cases.
        offer(CMD_WRITE, 8'd0, 24'hFFFFFF);
        offer(CMD_WRITE, 8'd63, 24'h000000);
        offer(CMD_WRITE, 8'd64, 24'hFFFFFF);       // first index past the strip
        offer(CMD_WRITE, 8'd255, 24'hFFFFFF);      // top index, also dropped
        offer(CMD_WRITE, 8'd1, 24'h80FF01);
        offer(CMD_TICK, 8'd0, 24'h0);              // idle tick
        offer(CMD_RESERVED, 8'd255, 24'hFFFFFF);   // reserved command
        offer(CMD_TICK, 8'd255, 24'hFFFFFF);
        offer(CMD_START, 8'd0, 24'h0);
        offer(CMD_START, 8'd0, 24'h0);             // start while a frame runs
        repeat (6) offer(CMD_TICK, 8'd0, 24'h0);
        offer(CMD_WRITE, 8'd0, 24'h00FF00);        // rewrite the pixel being sent
        offer(CMD_WRITE, 8'd2, 24'h5A5A5A);        // pixel not yet sent
        repeat (6) offer(CMD_TICK, 8'd0, 24'h0);

        // Random phases, each at its own zero-bit duty.
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                i_cfg_we    <= 1'b1;
                i_cfg_wdata <= phase_duty[p];
                @(posedge i_clk);
                i_cfg_we    <= 1'b0;
            end
            calm = (p == 2);   // phase 2 runs with no idling at all
            n    = 0;
            while (n < PHASE_MIN) begin
                // mid-frame in phase 0: receiver stalls, the block fills and stops taking
                if (p == 0 && n == 60) hold_req++;
                random_item();
                n++;
            end
        end
        calm = 1'b0;

        settle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
